[rtl/assert_macros.svh]
// Assertion macros for the RTL of the interval overlap admission block.
// Clocked, reset-qualified property checks; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a condition at every clock edge outside reset
`define IOA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that a condition in one cycle is followed by another in the next
`define IOA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IOA_ASSERT(lbl, clk, rst, prop, msg)
`define IOA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/ioa_pkg.sv]
// Package for the interval overlap admission block: widths, codes, token types.
// No dependencies; used by the request and config interfaces, the cell and the top level.
package ioa_pkg;

  localparam int VAL_W             = 16;
  localparam int LIMIT_W           = 7;
  localparam int MAX_INTERVALS_DEF = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd3;

  // request codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  // sweep phase carried by the token
  typedef enum logic [6:0] {
    PH_SEEK_S = 7'b000_0001,  // insert: pass entries below the new start
    PH_EMIT_S = 7'b000_0010,  // insert: end already placed, place the start
    PH_SEEK_E = 7'b000_0100,  // insert: pass entries up to the new end
    PH_COPY   = 7'b000_1000,  // insert: shift the rest of the table
    PH_Q1     = 7'b001_0000,  // query: count entries below the query start
    PH_Q2     = 7'b010_0000,  // query: count and check up to the query end
    PH_DONE   = 7'b100_0000   // nothing left to do
  } phase_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_end;
  } entry_t;

  // token handed from cell to cell
  typedef struct packed {
    logic       valid;
    phase_t     phase;
    entry_t     q0;     // displaced entries still to be written, oldest first
    entry_t     q1;
    logic [1:0] qcnt;
    logic       ok;     // query answer so far
  } tok_t;

endpackage

[rtl/ioa_req_if.sv]
// Request channel of the interval overlap admission block.
// Depends on ioa_pkg for field widths.
interface ioa_req_if;
  import ioa_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [VAL_W-1:0] start_point;
  logic [VAL_W-1:0] end_point;

  modport source (output valid, func, start_point, end_point, input ready);
  modport sink   (input valid, func, start_point, end_point, output ready);
endinterface

[rtl/ioa_rsp_if.sv]
// Result channel of the interval overlap admission block.
// One beat per request: query answer and table-full flag.
interface ioa_rsp_if;
  logic valid;
  logic ready;
  logic can_add;
  logic table_full;

  modport source (output valid, can_add, table_full, input ready);
  modport sink   (input valid, can_add, table_full, output ready);
endinterface

[rtl/ioa_cfg_if.sv]
// Configuration write channel of the interval overlap admission block.
// Depends on ioa_pkg for the limit width.
interface ioa_cfg_if;
  import ioa_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] overlap_limit;

  modport source (output valid, overlap_limit, input ready);
  modport sink   (input valid, overlap_limit, output ready);
endinterface

[rtl/ioa_cell.sv]
// One table cell: holds one endpoint and processes the token passing through.
// Depends on ioa_pkg for the entry and token types.
module ioa_cell #(
  parameter int DEPTH = 2 * ioa_pkg::MAX_INTERVALS_DEF,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(DEPTH+1)-1:0]            n,
  input  logic [ioa_pkg::LIMIT_W-1:0]           limit,
  input  logic [ioa_pkg::VAL_W-1:0]             sp,
  input  logic [ioa_pkg::VAL_W-1:0]             ep,
  input  ioa_pkg::tok_t                         tok_in,
  input  logic signed [$clog2(DEPTH+1):0]       cnt_in,
  output ioa_pkg::tok_t                         tok_out,
  output logic signed [$clog2(DEPTH+1):0]       cnt_out
);
  import ioa_pkg::*;

  localparam int N_W = $clog2(DEPTH + 1);
  localparam int CW  = N_W + 1;
  localparam int LW  = (CW > LIMIT_W) ? CW + 1 : LIMIT_W + 1;

  entry_t           entry;
  logic             occ;
  logic             avail;
  entry_t           x;
  entry_t           l0, l1, l2;
  logic [1:0]       len;
  logic             emit_x, emit_s, emit_e;
  logic             ins_ph;
  entry_t           e_out;
  logic signed [CW-1:0] cnt_step;
  logic             hit;
  tok_t             tok_nx;
  logic signed [CW-1:0] cnt_nx;

  // occupancy and the next entry of the old order
  assign occ   = (N_W'(IDX) < n);
  assign avail = (tok_in.qcnt != 2'd0) || occ;
  assign x     = (tok_in.qcnt != 2'd0) ? tok_in.q0 : entry;

  // pending list: queued entries followed by this cell's own entry
  assign l0  = (tok_in.qcnt != 2'd0) ? tok_in.q0 : entry;
  assign l1  = (tok_in.qcnt == 2'd2) ? tok_in.q1 : entry;
  assign l2  = entry;
  assign len = tok_in.qcnt + {1'b0, occ};

  // running overlap count for queries
  assign cnt_step = entry.is_end ? (cnt_in - CW'(1)) : (cnt_in + CW'(1));
  assign hit = !cnt_step[CW-1] &&
               (LW'($unsigned(cnt_step)) == LW'(limit));

  // phase step
  always_comb begin
    tok_nx = tok_in;
    cnt_nx = cnt_in;
    emit_x = 1'b0;
    emit_s = 1'b0;
    emit_e = 1'b0;
    ins_ph = 1'b0;
    unique case (tok_in.phase) inside
      PH_SEEK_S: begin
        ins_ph = 1'b1;
        if (avail && (x.value < sp)) begin
          emit_x = 1'b1;
        end else if (ep < sp) begin
          emit_e = 1'b1;
          tok_nx.phase = PH_EMIT_S;
        end else begin
          emit_s = 1'b1;
          tok_nx.phase = PH_SEEK_E;
        end
      end
      PH_EMIT_S: begin
        ins_ph = 1'b1;
        emit_s = 1'b1;
        tok_nx.phase = PH_COPY;
      end
      PH_SEEK_E: begin
        ins_ph = 1'b1;
        if (avail && (x.value <= ep)) begin
          emit_x = 1'b1;
        end else begin
          emit_e = 1'b1;
          tok_nx.phase = PH_COPY;
        end
      end
      PH_COPY: begin
        ins_ph = 1'b1;
        emit_x = avail;
      end
      PH_Q1, PH_Q2: begin
        if ((tok_in.phase == PH_Q1) && occ && (entry.value < sp)) begin
          cnt_nx = cnt_step;
        end else if (occ && (entry.value <= ep)) begin
          cnt_nx = cnt_step;
          if (hit) begin
            tok_nx.ok    = 1'b0;
            tok_nx.phase = PH_DONE;
          end else begin
            tok_nx.phase = PH_Q2;
          end
        end else begin
          tok_nx.phase = PH_DONE;
        end
      end
      PH_DONE: begin
        tok_nx.phase = PH_DONE;
      end
      default: begin
        tok_nx.phase = PH_DONE;
      end
    endcase

    // queue of displaced entries during an insert
    if (ins_ph) begin
      if (emit_x) begin
        tok_nx.q0   = l1;
        tok_nx.q1   = l2;
        tok_nx.qcnt = len - 2'd1;
      end else begin
        tok_nx.q0   = l0;
        tok_nx.q1   = l1;
        tok_nx.qcnt = len;
      end
    end
  end

  // entry written into this cell
  always_comb begin
    if (emit_x) begin
      e_out = x;
    end else if (emit_s) begin
      e_out = '{value: sp, is_end: 1'b0};
    end else begin
      e_out = '{value: ep, is_end: 1'b1};
    end
  end

  // stored endpoint
  always_ff @(posedge clk) begin
    if (tok_in.valid && (emit_x || emit_s || emit_e)) begin
      entry <= e_out;
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_nx;
    end
  end

  always_ff @(posedge clk) begin
    cnt_out <= cnt_nx;
  end

endmodule

[rtl/interval_overlap_admission.sv]
// Interval overlap admission: a row of endpoint cells swept by one token.
// Uses ioa_pkg, the three channel interfaces, ioa_cell and assert_macros.svh.
//
// Usage:
//   req carries func, start_point and end_point. func = FUNC_INSERT stores the
//   interval in the endpoint table; func = FUNC_QUERY asks whether the running
//   overlap count over the table reaches overlap_limit inside the interval.
//   rsp returns one beat per request: can_add (queries) and table_full
//   (inserts dropped because the table has no room for two more endpoints).
//   cfg writes overlap_limit; write it only while no request is in flight.
// Flow:
//   A request is carried by a token through 2*MAX_INTERVALS cells, one cell
//   per cycle, from the launch register through the cell registers to the
//   holding stage and then the output register. One request is in flight at
//   a time; the next request beat is taken once the result has moved from
//   the holding stage into the output register.
// Reset: clears the table count (the table is empty), sets overlap_limit to 3
//   and drops any request in flight.
// Stall: a result waits in the output register; a finished second result
//   waits in a holding stage, and req stays not ready until it moves on.
module interval_overlap_admission #(
  parameter int MAX_INTERVALS = ioa_pkg::MAX_INTERVALS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ioa_req_if.sink   req,
  ioa_rsp_if.source rsp,
  ioa_cfg_if.sink   cfg
);
  import ioa_pkg::*;

  localparam int DEPTH = 2 * MAX_INTERVALS;
  localparam int N_W   = $clog2(DEPTH + 1);
  localparam int CW    = N_W + 1;

  logic [LIMIT_W-1:0]   limit;
  logic [N_W-1:0]       entry_count;
  logic [VAL_W-1:0]     sp_q, ep_q;
  logic                 grow_q, full_q;
  logic                 busy;
  logic                 accept;
  logic                 full_now;
  tok_t                 launch, launch_next;
  tok_t                 tok [0:DEPTH];
  logic signed [CW-1:0] cnt [0:DEPTH];
  logic [DEPTH:0]       tok_vld;
  logic                 held_valid, held_can, held_full;
  logic                 out_valid, out_can, out_full;
  logic                 out_load;

  // request handshake
  assign req.ready = !busy;
  assign accept    = req.valid && !busy;
  assign cfg.ready = 1'b1;
  assign full_now  = (req.func == FUNC_INSERT) && (entry_count > N_W'(DEPTH - 2));

  // token launched at the head of the chain
  always_comb begin
    launch_next       = '0;
    launch_next.valid = 1'b1;
    launch_next.ok    = (req.func == FUNC_QUERY);
    if (req.func == FUNC_QUERY) begin
      launch_next.phase = PH_Q1;
    end else if (full_now) begin
      launch_next.phase = PH_DONE;
    end else begin
      launch_next.phase = PH_SEEK_S;
    end
  end

  assign tok[0] = launch;
  assign cnt[0] = '0;

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    ioa_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .n       (entry_count),
      .limit   (limit),
      .sp      (sp_q),
      .ep      (ep_q),
      .tok_in  (tok[k]),
      .cnt_in  (cnt[k]),
      .tok_out (tok[k+1]),
      .cnt_out (cnt[k+1])
    );
  end

  for (genvar k = 0; k <= DEPTH; k++) begin : g_vld
    assign tok_vld[k] = tok[k].valid;
  end

  // output register fed from the holding stage
  assign out_load = held_valid && (!out_valid || rsp.ready);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= LIMIT_RST;
      entry_count  <= '0;
      launch.valid <= 1'b0;
      busy         <= 1'b0;
      held_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        limit <= cfg.overlap_limit;
      end
      if (accept) begin
        launch <= launch_next;
        busy   <= 1'b1;
      end else begin
        launch.valid <= 1'b0;
      end
      if (tok[DEPTH].valid) begin
        held_valid <= 1'b1;
        if (grow_q) begin
          entry_count <= entry_count + N_W'(2);
        end
      end else if (out_load) begin
        held_valid <= 1'b0;
        busy       <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sp_q   <= req.start_point;
      ep_q   <= req.end_point;
      full_q <= full_now;
      grow_q <= (req.func == FUNC_INSERT) && !full_now;
    end
    if (tok[DEPTH].valid) begin
      held_can  <= tok[DEPTH].ok;
      held_full <= full_q;
    end
    if (out_load) begin
      out_can  <= held_can;
      out_full <= held_full;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.can_add    = out_can;
  assign rsp.table_full = out_full;

`include "assert_macros.svh"

  `IOA_ASSERT(a_one_token, clk, rst, $onehot0(tok_vld), "more than one token in the chain")
  `IOA_ASSERT(a_count_range, clk, rst, (entry_count <= N_W'(DEPTH)) && !entry_count[0], "table count out of range")
  `IOA_ASSERT(a_idle_empty, clk, rst, busy || ((tok_vld == '0) && !held_valid), "ready while a request is in flight")
  `IOA_ASSERT_NEXT(a_launch, clk, rst, accept, tok_vld[0] && busy, "accepted request did not launch a token")
  `IOA_ASSERT_NEXT(a_exit_held, clk, rst, tok_vld[DEPTH], held_valid, "finished token did not reach the holding stage")

endmodule
